// File: rtl/sast_pkg.sv
// sast_pkg: shared types and codes for the sorted address symbol table
// no dependencies
package sast_pkg;
	localparam logic [1:0] REQ_INSERT = 2'd0;
	localparam logic [1:0] REQ_LOOKUP = 2'd1;
	localparam logic [1:0] REQ_CLEAR  = 2'd2;

	localparam logic [2:0] ST_INSERTED = 3'd0;
	localparam logic [2:0] ST_DUP      = 3'd1;
	localparam logic [2:0] ST_FULL     = 3'd2;
	localparam logic [2:0] ST_EXACT    = 3'd3;
	localparam logic [2:0] ST_NEAR     = 3'd4;
	localparam logic [2:0] ST_MISS     = 3'd5;
	localparam logic [2:0] ST_CLEARED  = 3'd6;

	localparam logic [31:0] NEAR_LIMIT_RESET = 32'h0020_0000;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [31:0] address;
		logic [15:0] name_id;
	} sast_req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] found_id;
		logic [31:0] offset;
	} sast_rsp_t;
endpackage

// File: rtl/sast_front.sv
// sast_front: accepts request items, drops unused codes, two-entry queue
// depends on sast_pkg
module sast_front
	import sast_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  sast_req_t   in_req,
	output logic        q_valid,
	input  logic        q_ready,
	output sast_req_t   q_req
);
	sast_req_t  mem_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	logic       push, pop, legal;

	assign legal    = (in_req.req_type == REQ_INSERT) || (in_req.req_type == REQ_LOOKUP)
		|| (in_req.req_type == REQ_CLEAR);
	assign in_ready = (cnt_q != 2'd2);
	assign push     = in_valid && in_ready && legal;
	assign q_valid  = (cnt_q != 2'd0);
	assign pop      = q_valid && q_ready;
	assign q_req    = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= in_req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

// File: rtl/sast_back.sv
// sast_back: result register between the search engine and m_axis
// depends on sast_pkg
module sast_back
	import sast_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  sast_rsp_t   in_rsp,
	output logic        out_valid,
	input  logic        out_ready,
	output sast_rsp_t   out_rsp
);
	logic      valid_q;
	sast_rsp_t rsp_q;

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_rsp   = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			if (in_valid && in_ready) valid_q <= 1'b1;
			else if (out_ready) valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) rsp_q <= in_rsp;
	end
endmodule

// File: rtl/sast_engine.sv
// sast_engine: binary search and shift engine over the entry memory
// depends on sast_pkg
module sast_engine
	import sast_pkg::*;
#(
	parameter int CAPACITY = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [31:0] near_limit,
	input  logic        q_valid,
	output logic        q_ready,
	input  sast_req_t   q_req,
	output logic        out_valid,
	input  logic        out_ready,
	output sast_rsp_t   out_rsp
);
	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_RD    = 3'd1;
	localparam logic [2:0] S_CMP   = 3'd2;
	localparam logic [2:0] S_PRED  = 3'd3;
	localparam logic [2:0] S_DEC   = 3'd4;
	localparam logic [2:0] S_SRD   = 3'd5;
	localparam logic [2:0] S_SWR   = 3'd6;

	logic [31:0]   mem_addr [CAPACITY];
	logic [15:0]   mem_hdl  [CAPACITY];
	logic [2:0]    state_q;
	logic [CW-1:0] count_q, lo_q, hi_q, k_q;
	sast_req_t     req_q;
	logic [AW-1:0] rd_idx;
	logic [31:0]   rdata_a_q;
	logic [15:0]   rdata_h_q;
	logic          we;
	logic [AW-1:0] wa;
	logic [31:0]   wd_a;
	logic [15:0]   wd_h;
	logic [CW:0]   mid_w;
	logic [CW-1:0] mid;
	logic [31:0]   diff;
	logic          hit;
	sast_rsp_t     dec_rsp;

	assign mid_w = ({1'b0, lo_q} + {1'b0, hi_q}) >> 1;
	assign mid   = mid_w[CW-1:0];
	assign diff  = req_q.address - rdata_a_q;
	assign hit   = (lo_q != '0) && (diff == 32'd0);

	always_comb begin
		case (state_q)
			S_PRED:  rd_idx = AW'(lo_q - CW'(1));
			S_SRD:   rd_idx = AW'(k_q - CW'(1));
			default: rd_idx = mid[AW-1:0];
		endcase
	end

	always_comb begin
		we   = 1'b0;
		wa   = k_q[AW-1:0];
		wd_a = rdata_a_q;
		wd_h = rdata_h_q;
		if (state_q == S_SWR) begin
			we = 1'b1;
			if (k_q == lo_q) begin
				wd_a = req_q.address;
				wd_h = req_q.name_id;
			end
		end
	end

	always_comb begin
		dec_rsp = '{status: ST_MISS, found_id: 16'd0, offset: 32'd0};
		if (hit) begin
			dec_rsp.status   = (req_q.req_type == REQ_INSERT) ? ST_DUP : ST_EXACT;
			dec_rsp.found_id = rdata_h_q;
		end else if (req_q.req_type == REQ_INSERT) begin
			dec_rsp.status = (count_q >= CW'(CAPACITY)) ? ST_FULL : ST_INSERTED;
		end else if (lo_q != '0 && diff < near_limit) begin
			dec_rsp.status   = ST_NEAR;
			dec_rsp.found_id = rdata_h_q;
			dec_rsp.offset   = diff;
		end
	end

	always_ff @(posedge clk) begin
		rdata_a_q <= mem_addr[rd_idx];
		rdata_h_q <= mem_hdl[rd_idx];
		if (we) begin
			mem_addr[wa] <= wd_a;
			mem_hdl[wa]  <= wd_h;
		end
	end

	assign q_ready = (state_q == S_IDLE) && !out_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (q_valid && q_ready) begin
						if (q_req.req_type == REQ_CLEAR) begin
							count_q   <= '0;
							out_valid <= 1'b1;
						end else begin
							state_q <= S_RD;
						end
					end
				end
				S_RD:   state_q <= (hi_q > lo_q) ? S_CMP : S_PRED;
				S_CMP:  state_q <= S_RD;
				S_PRED: state_q <= S_DEC;
				S_DEC: begin
					if (req_q.req_type == REQ_INSERT && !hit && count_q < CW'(CAPACITY))
						state_q <= S_SRD;
					else begin
						state_q   <= S_IDLE;
						out_valid <= 1'b1;
					end
				end
				S_SRD: state_q <= S_SWR;
				S_SWR: begin
					if (k_q == lo_q) begin
						count_q   <= count_q + CW'(1);
						state_q   <= S_IDLE;
						out_valid <= 1'b1;
					end else begin
						state_q <= S_SRD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (q_valid && q_ready) begin
					req_q   <= q_req;
					lo_q    <= '0;
					hi_q    <= count_q;
					out_rsp <= '{status: ST_CLEARED, found_id: 16'd0, offset: 32'd0};
				end
			end
			S_CMP: begin
				if (rdata_a_q > req_q.address) hi_q <= mid;
				else lo_q <= mid + CW'(1);
			end
			S_PRED: k_q <= count_q;
			S_DEC: out_rsp <= dec_rsp;
			S_SWR: if (k_q != lo_q) k_q <= k_q - CW'(1);
			default: ;
		endcase
	end
endmodule

// File: rtl/sorted_address_symbol_table_core.sv
// sorted_address_symbol_table_core: top level of the sorted symbol table
// depends on sast_pkg, sast_front, sast_engine, sast_back
//
// requests enter on s_axis (req_type in tuser, address and name_id in tdata);
// unused req_type codes are dropped without a result. one result per request
// leaves on m_axis (status in tuser, found_id and offset in tdata).
// near_limit is written on the cfg channel; the user must write it only while
// the block is idle, as the block itself does not enforce this. a two-item
// queue decouples intake from the search engine, and a result register
// parts the engine from m_axis. a clear needs no search. a lookup takes s
// binary search steps, s at most log2(CAPACITY)+1, with one memory read per
// step; an insert then shifts each entry above the new slot up by one and
// writes the new entry. one request is worked at a time.
// while m_axis is stalled the result register holds, the engine finishes one
// more item and the queue keeps taking items until it is full.
// reset empties the table and restores near_limit to 0x200000.
// table contents are not cleared at reset; the fill count bounds every read.
module sorted_address_symbol_table_core
	import sast_pkg::*;
#(
	parameter int CAPACITY = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,  // address, name_id
	input  logic [1:0]  s_axis_tuser,  // req_type
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,  // found_id, offset
	output logic [2:0]  m_axis_tuser,  // status
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data
);
	logic [31:0] near_limit_q;
	sast_req_t   in_req, q_req;
	sast_rsp_t   e_rsp, rsp;
	logic        q_valid, q_ready;
	logic        e_valid, e_ready;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) near_limit_q <= NEAR_LIMIT_RESET;
		else if (cfg_valid) near_limit_q <= cfg_data;
	end

	assign in_req = '{req_type: s_axis_tuser, address: s_axis_tdata[31:0],
		name_id: s_axis_tdata[47:32]};

	sast_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_req(in_req),
		.q_valid(q_valid), .q_ready(q_ready), .q_req(q_req)
	);

	sast_engine #(.CAPACITY(CAPACITY)) u_engine (
		.clk(clk), .arst_n(arst_n), .near_limit(near_limit_q),
		.q_valid(q_valid), .q_ready(q_ready), .q_req(q_req),
		.out_valid(e_valid), .out_ready(e_ready), .out_rsp(e_rsp)
	);

	sast_back u_back (
		.clk(clk), .arst_n(arst_n),
		.in_valid(e_valid), .in_ready(e_ready), .in_rsp(e_rsp),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_rsp(rsp)
	);

	assign m_axis_tuser = rsp.status;
	assign m_axis_tdata = {rsp.offset, rsp.found_id};
endmodule

// File: rtl/sast_checker.sv
// sast_checker: port-level assertions for the symbol table core
// depends on sast_pkg; bound to sorted_address_symbol_table_core
module sast_checker
	import sast_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [47:0] m_axis_tdata,
	input logic [2:0]  m_axis_tuser
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tuser != 3'd7)
		else $error("bad status");
	a_off: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != ST_NEAR |-> m_axis_tdata[47:16] == 32'd0)
		else $error("offset outside near hit");
	a_id: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == ST_INSERTED || m_axis_tuser == ST_FULL
		|| m_axis_tuser == ST_MISS || m_axis_tuser == ST_CLEARED)
		|-> m_axis_tdata[15:0] == 16'd0)
		else $error("handle on non-match");
endmodule

bind sorted_address_symbol_table_core sast_checker u_chk (
	.clk(clk), .arst_n(arst_n), .m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
	.m_axis_tuser(m_axis_tuser)
);

// File: sim/tb_top.sv
// tb_top: self-checking testbench for sorted_address_symbol_table_core
// drives requests and near_limit writes, predicts every result, compares on m_axis
// depends on sast_pkg and the core rtl
module tb_top;
	import sast_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAP = 256;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata;  // address, name_id
	logic [1:0]  s_axis_tuser;  // req_type
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [47:0] m_axis_tdata;  // found_id, offset
	logic [2:0]  m_axis_tuser;  // status
	logic        cfg_valid;
	logic        cfg_ready;
	logic [31:0] cfg_data;

	sorted_address_symbol_table_core #(.CAPACITY(CAP)) dut (.*);

	sast_req_t pending_items[$];
	sast_rsp_t expected_rsps[$];
	logic [31:0] tbl_addr[CAP];
	logic [15:0] tbl_id[CAP];
	int          tbl_count = 0;
	logic [31:0] near_limit_q;
	int          errors = 0;
	int          hold_off;
	bit          hold_done;
	int          rx_count;
	bit          stall_now;
	int          gap_left;
	int          burst_left;

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	function automatic int upper_slot(logic [31:0] a);
		int lo;
		int hi;
		int mid;
		lo = 0;
		hi = tbl_count;
		while (hi > lo) begin
			mid = (lo + hi) / 2;
			if (tbl_addr[mid] > a) hi = mid;
			else lo = mid + 1;
		end
		return lo;
	endfunction

	// applies one request to the table copy and queues its result, if it has one
	function automatic void predict_table(sast_req_t r);
		sast_rsp_t e;
		int s;
		logic [31:0] d;
		e = '0;
		if (r.req_type == REQ_INSERT) begin
			s = upper_slot(r.address);
			if (s > 0 && tbl_addr[s-1] == r.address) begin
				e.status = ST_DUP;
				e.found_id = tbl_id[s-1];
			end else if (tbl_count >= CAP) begin
				e.status = ST_FULL;
			end else begin
				for (int k = tbl_count; k > s; k--) begin
					tbl_addr[k] = tbl_addr[k-1];
					tbl_id[k] = tbl_id[k-1];
				end
				tbl_addr[s] = r.address;
				tbl_id[s] = r.name_id;
				tbl_count++;
				e.status = ST_INSERTED;
			end
		end else if (r.req_type == REQ_LOOKUP) begin
			s = upper_slot(r.address);
			e.status = ST_MISS;
			if (s > 0) begin
				d = r.address - tbl_addr[s-1];
				if (d == 0) begin
					e.status = ST_EXACT;
					e.found_id = tbl_id[s-1];
				end else if (d < near_limit_q) begin
					e.status = ST_NEAR;
					e.found_id = tbl_id[s-1];
					e.offset = d;
				end
			end
		end else if (r.req_type == REQ_CLEAR) begin
			tbl_count = 0;
			e.status = ST_CLEARED;
		end else begin
			return;
		end
		expected_rsps.push_back(e);
	endfunction

	// driver: bursts with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tuser <= '0;
			gap_left <= 0;
			burst_left <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				predict_table(pending_items.pop_front());
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					s_axis_tvalid <= 1'b0;
				end else if (pending_items.size() > 0 && !cfg_valid) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tuser <= pending_items[0].req_type;
					s_axis_tdata <= {pending_items[0].name_id, pending_items[0].address};
					if (burst_left == 0) begin
						burst_left <= $urandom_range(1, 12);
						gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 20);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver stall pattern plus one long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			stall_now <= 1'b0;
			hold_off <= 0;
			hold_done <= 1'b0;
			rx_count <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) rx_count <= rx_count + 1;
			if ($urandom_range(0, 15) == 0) stall_now <= ~stall_now;
			if (!hold_done && rx_count == 100) begin
				hold_done <= 1'b1;
				hold_off <= 400;
				m_axis_tready <= 1'b0;
			end else if (hold_off > 0) begin
				hold_off <= hold_off - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= stall_now ? ($urandom_range(0, 3) == 0) : 1'b1;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		sast_rsp_t e;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_rsps.size() == 0) begin
				$display("%0t unexpected result status=%0d data=%h", $time,
					m_axis_tuser, m_axis_tdata);
				errors++;
			end else begin
				e = expected_rsps.pop_front();
				if (m_axis_tuser !== e.status) begin
					$display("%0t status expected %0d actual %0d", $time, e.status,
						m_axis_tuser);
					errors++;
				end
				if (m_axis_tdata[15:0] !== e.found_id) begin
					$display("%0t found_id expected %h actual %h", $time, e.found_id,
						m_axis_tdata[15:0]);
					errors++;
				end
				if (m_axis_tdata[47:16] !== e.offset) begin
					$display("%0t offset expected %h actual %h", $time, e.offset,
						m_axis_tdata[47:16]);
					errors++;
				end
			end
		end
	end

	function automatic logic [31:0] pick_addr(int mode);
		if (mode == 0 && tbl_count > 0 && $urandom_range(0, 1))
			return tbl_addr[$urandom_range(0, tbl_count - 1)] + $urandom_range(0, 3);
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 63) << 12;
			1: return $urandom;
			2: return 32'hFFFF_FFFF - $urandom_range(0, 3);
			default: return $urandom_range(0, 2000);
		endcase
	endfunction

	function automatic void add_item(logic [1:0] t, logic [31:0] a, logic [15:0] n);
		sast_req_t r;
		r.req_type = t;
		r.address = a;
		r.name_id = n;
		pending_items.push_back(r);
	endfunction

	task automatic drain_and_write(logic [31:0] v);
		while (pending_items.size() > 0 || expected_rsps.size() > 0) @(posedge clk);
		repeat (2 * CAP + 40) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		near_limit_q = v;
		@(posedge clk);
	endtask

	initial begin
		int r;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		near_limit_q = NEAR_LIMIT_RESET;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed
		add_item(REQ_LOOKUP, 32'h1000, 16'h0);
		add_item(REQ_INSERT, 32'h0, 16'hFFFF);
		add_item(REQ_INSERT, 32'hFFFF_FFFF, 16'hA5A5);
		add_item(REQ_INSERT, 32'hFFFF_FFFF, 16'h1234);
		add_item(REQ_INSERT, 32'h0, 16'h5A5A);
		add_item(REQ_INSERT, 32'h8000_0000, 16'h0);
		add_item(REQ_LOOKUP, 32'h0, 16'h0);
		add_item(REQ_LOOKUP, 32'h0000_0010, 16'hFFFF);
		add_item(REQ_LOOKUP, 32'h7FFF_FFFF, 16'h0);
		add_item(REQ_LOOKUP, 32'h8000_0001, 16'h0);
		add_item(REQ_LOOKUP, 32'hFFFF_FFFF, 16'h0);
		add_item(2'd3, 32'hFFFF_FFFF, 16'hFFFF);
		add_item(REQ_CLEAR, 32'h0, 16'h0);
		add_item(REQ_LOOKUP, 32'hFFFF_FFFF, 16'h0);
		drain_and_write(32'h0);
		add_item(REQ_INSERT, 32'h100, 16'h1);
		add_item(REQ_LOOKUP, 32'h101, 16'h0);
		add_item(REQ_LOOKUP, 32'h100, 16'h0);
		drain_and_write(32'hFFFF_FFFF);
		add_item(REQ_LOOKUP, 32'hFFFF_FFFF, 16'h0);
		// fill to capacity, then full and dup at end
		for (int i = 0; i < CAP + 3; i++) add_item(REQ_INSERT, $urandom, 16'($urandom));
		add_item(REQ_INSERT, 32'h100, 16'h2);
		add_item(REQ_INSERT, 32'hFFFF_FFFF, 16'h3);
		add_item(REQ_LOOKUP, $urandom, 16'h0);
		for (int i = 0; i < 10; i++) add_item(REQ_LOOKUP, $urandom, 16'h0);
		add_item(REQ_CLEAR, 32'h0, 16'h0);
		drain_and_write(NEAR_LIMIT_RESET);

		// random phases with different limits
		for (int ph = 0; ph < 4; ph++) begin
			for (int i = 0; i < 55; i++) begin
				r = $urandom_range(0, 99);
				if (r < 45) add_item(REQ_INSERT, pick_addr(0), 16'($urandom));
				else if (r < 92) add_item(REQ_LOOKUP, pick_addr(0), 16'($urandom));
				else if (r < 96) add_item(REQ_CLEAR, $urandom, 16'($urandom));
				else add_item(2'd3, $urandom, 16'($urandom));
			end
			case (ph)
				0: drain_and_write(32'h1);
				1: drain_and_write($urandom_range(2, 5000));
				2: drain_and_write($urandom);
				default: drain_and_write(NEAR_LIMIT_RESET);
			endcase
		end

		if (errors == 0) $display("No mismatches found");
		else $display("Mismatches found");
		$finish;
	end

	initial begin
		#40ms;
		$display("Mismatches found");
		$finish;
	end
endmodule

// File: files.f
rtl/sast_pkg.sv
rtl/sast_front.sv
rtl/sast_back.sv
rtl/sast_engine.sv
rtl/sorted_address_symbol_table_core.sv
rtl/sast_checker.sv
sim/tb_top.sv
